>>> rtl/core/pcct_pkg.sv
// Shared types and constants of the point-to-capsule collision test.
`timescale 1ns / 1ps
`default_nettype none

package pcct_pkg;

	localparam int IDX_W     = 16;
	localparam int CRD_W     = 32;
	localparam int LEN_W     = 31;
	localparam int DIST2_W   = 62;
	localparam int CFG_IDX_W = 3;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int SQ_STEPS  = 31;
	localparam int DIV_STEPS = 31;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_X = 3'd0,
		REG_BASE_Y = 3'd1,
		REG_BASE_Z = 3'd2,
		REG_AXIS_X = 3'd3,
		REG_AXIS_Y = 3'd4,
		REG_AXIS_Z = 3'd5,
		REG_SEG_LENGTH = 3'd6,
		REG_CAP_RADIUS = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0][CRD_W-1:0] base;
		logic [2:0][CRD_W-1:0] axis;
		logic [LEN_W-1:0]      len;
		logic [LEN_W-1:0]      radius;
	} pcct_cfg_t;

	// One hit waiting for the surface vector stage
	typedef struct packed {
		logic [IDX_W-1:0]      idx;
		logic [2:0][CRD_W-1:0] w;
		logic [DIST2_W-1:0]    dist2;
	} pcct_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pcct_qstat_t;

endpackage

`default_nettype wire

>>> rtl/core/pcct_front.sv
// Front pipeline: bounding sphere test, axis projection and hit test.
`timescale 1ns / 1ps
`default_nettype none

module pcct_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pcct_pkg::pcct_cfg_t               cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pcct_pkg::IDX_W-1:0]        in_idx,
	input  logic [2:0][pcct_pkg::CRD_W-1:0]   in_pt,
	input  pcct_pkg::pcct_qstat_t             qstat,
	output logic                              push,
	output pcct_pkg::pcct_entry_t             push_data
);
	import pcct_pkg::*;

	logic fe;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7, idx_s8;
	logic signed [32:0] d_s1 [3];
	logic signed [32:0] d_s2 [3];
	logic signed [32:0] d_s3 [3];
	logic signed [32:0] d_s4 [3];
	logic signed [63:0] al_s1 [3];
	logic signed [35:0] vb_s2 [3];
	logic signed [64:0] da_s2 [3];
	logic [32:0] sl_s2;
	logic [69:0] vv_s3 [3];
	logic [LEN_W-1:0] t_s3;
	logic [65:0] ss_s3, ss_s4;
	logic [71:0] vsum_s4;
	logic signed [63:0] at_s4 [3];
	logic outside_s5, outside_s6, outside_s7;
	logic signed [35:0] w_s5 [3];
	logic signed [35:0] w_s6 [3];
	logic signed [35:0] w_s7 [3];
	logic signed [35:0] w_s8 [3];
	logic [61:0] rr_s5, rr_s6, rr_s7;
	logic [69:0] ww_s6 [3];
	logic [71:0] wsum_s7;
	logic hit_s8;
	logic [DIST2_W-1:0] dist2_s8;

	logic signed [63:0] h_c [3];
	logic signed [35:0] v_c [3];
	logic signed [64:0] tr_c [3];
	logic signed [36:0] tsum_c;
	logic [LEN_W-1:0] t_c;
	logic [34:0] vmag_c [3];
	logic signed [63:0] e_c [3];
	logic signed [35:0] w_c [3];
	logic [34:0] wmag_c [3];

	// Stall the whole front only when a hit cannot enter the queue
	assign fe       = !(v_s8 && hit_s8 && qstat.full);
	assign in_ready = fe;
	assign push     = v_s8 && hit_s8 && !qstat.full;

	always_comb begin
		push_data.idx   = idx_s8;
		push_data.dist2 = dist2_s8;
		for (int i = 0; i < 3; i++) begin
			push_data.w[i] = w_s8[i][CRD_W-1:0];
		end
	end

	// Rounding, differences and magnitudes between stages
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			h_c[i]    = (al_s1[i] + 64'sd536870912) >>> 30;
			v_c[i]    = $signed({{2{d_s1[i][32]}}, d_s1[i], 1'b0}) - h_c[i][35:0];
			tr_c[i]   = (da_s2[i] + 65'sd536870912) >>> 30;
			vmag_c[i] = vb_s2[i][35] ? 35'(-vb_s2[i]) : vb_s2[i][34:0];
			e_c[i]    = (at_s4[i] + 64'sd536870912) >>> 30;
			w_c[i]    = $signed(e_c[i][35:0]) - $signed({{3{d_s4[i][32]}}, d_s4[i]});
			wmag_c[i] = w_s5[i][35] ? 35'(-w_s5[i]) : w_s5[i][34:0];
		end
		tsum_c = $signed(tr_c[0][36:0]) + $signed(tr_c[1][36:0]) + $signed(tr_c[2][36:0]);
		if (tsum_c < 0) begin
			t_c = '0;
		end else if (tsum_c > $signed({6'd0, cfg.len})) begin
			t_c = cfg.len;
		end else begin
			t_c = tsum_c[LEN_W-1:0];
		end
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (fe) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	// Advance stage payload
	always_ff @(posedge clk) begin
		if (fe) begin
			idx_s1 <= in_idx; idx_s2 <= idx_s1; idx_s3 <= idx_s2; idx_s4 <= idx_s3;
			idx_s5 <= idx_s4; idx_s6 <= idx_s5; idx_s7 <= idx_s6; idx_s8 <= idx_s7;
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= $signed({in_pt[i][CRD_W-1], in_pt[i]})
					- $signed({cfg.base[i][CRD_W-1], cfg.base[i]});
				al_s1[i] <= $signed(cfg.axis[i]) * $signed({1'b0, cfg.len});
				d_s2[i]  <= d_s1[i];
				vb_s2[i] <= v_c[i];
				da_s2[i] <= d_s1[i] * $signed(cfg.axis[i]);
				d_s3[i]  <= d_s2[i];
				vv_s3[i] <= vmag_c[i] * vmag_c[i];
				d_s4[i]  <= d_s3[i];
				at_s4[i] <= $signed(cfg.axis[i]) * $signed({1'b0, t_s3});
				w_s5[i]  <= w_c[i];
				w_s6[i]  <= w_s5[i];
				ww_s6[i] <= wmag_c[i] * wmag_c[i];
				w_s7[i]  <= w_s6[i];
				w_s8[i]  <= w_s7[i];
			end
			sl_s2      <= {1'b0, cfg.radius, 1'b0} + {2'b0, cfg.len};
			t_s3       <= t_c;
			ss_s3      <= sl_s2 * sl_s2;
			vsum_s4    <= 72'(vv_s3[0]) + 72'(vv_s3[1]) + 72'(vv_s3[2]);
			ss_s4      <= ss_s3;
			outside_s5 <= vsum_s4 > 72'(ss_s4);
			rr_s5      <= cfg.radius * cfg.radius;
			outside_s6 <= outside_s5;
			rr_s6      <= rr_s5;
			outside_s7 <= outside_s6;
			rr_s7      <= rr_s6;
			wsum_s7    <= 72'(ww_s6[0]) + 72'(ww_s6[1]) + 72'(ww_s6[2]);
			hit_s8     <= !outside_s7 && (wsum_s7 <= 72'(rr_s7));
			dist2_s8   <= wsum_s7[DIST2_W-1:0];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pcct_queue.sv
// Short queue of hits between the front and back pipelines.
`timescale 1ns / 1ps
`default_nettype none

module pcct_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pcct_pkg::pcct_entry_t  push_data,
	input  logic                   pop,
	output pcct_pkg::pcct_entry_t  pop_data,
	output pcct_pkg::pcct_qstat_t  qstat
);
	import pcct_pkg::*;

	pcct_entry_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0] cnt_q;

	assign pop_data    = mem_q[rptr_q];
	assign qstat.full  = cnt_q == (QPTR_W + 1)'(QDEPTH);
	assign qstat.empty = cnt_q == '0;

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

endmodule

`default_nettype wire

>>> rtl/core/pcct_back.sv
// Back pipeline: square root of the distance, scaling division, output register.
`timescale 1ns / 1ps
`default_nettype none

module pcct_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [pcct_pkg::LEN_W-1:0]        radius,
	input  pcct_pkg::pcct_qstat_t             qstat,
	output logic                              pop,
	input  pcct_pkg::pcct_entry_t             pop_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pcct_pkg::IDX_W-1:0]        out_idx,
	output logic [2:0][pcct_pkg::CRD_W-1:0]   out_pen
);
	import pcct_pkg::*;

	logic be;
	logic sq_v [0:SQ_STEPS];
	logic [63:0] sq_x [0:SQ_STEPS];
	logic [63:0] sq_r [0:SQ_STEPS];
	logic [IDX_W-1:0] sq_idx [0:SQ_STEPS];
	logic [2:0][CRD_W-1:0] sq_w [0:SQ_STEPS];

	logic mul_v_s1;
	logic [IDX_W-1:0] mul_idx_s1;
	logic [2:0][CRD_W-1:0] mul_w_s1;
	logic [LEN_W-1:0] mul_dist_s1;
	logic [2:0][61:0] mul_n_s1;
	logic [LEN_W-1:0] wmag_c [3];

	logic dv_v [0:DIV_STEPS];
	logic [2:0][63:0] dv_rem [0:DIV_STEPS];
	logic [2:0][LEN_W-1:0] dv_quo [0:DIV_STEPS];
	logic [LEN_W-1:0] dv_dist [0:DIST2_W > 0 ? DIV_STEPS : 0];
	logic [IDX_W-1:0] dv_idx [0:DIV_STEPS];
	logic [2:0][CRD_W-1:0] dv_w [0:DIV_STEPS];

	logic signed [32:0] p_c [3];
	logic out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [2:0][CRD_W-1:0] out_pen_q;

	// Whole back pipeline stalls while the output register is held
	assign be        = !out_valid_q || out_ready;
	assign pop       = be && !qstat.empty;
	assign out_valid = out_valid_q;
	assign out_idx   = out_idx_q;
	assign out_pen   = out_pen_q;

	// Advance valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SQ_STEPS; k++) sq_v[k] <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) dv_v[k] <= 1'b0;
			mul_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (be) begin
			sq_v[0] <= pop;
			for (int k = 0; k < SQ_STEPS; k++) sq_v[k+1] <= sq_v[k];
			mul_v_s1 <= sq_v[SQ_STEPS];
			dv_v[0]  <= mul_v_s1;
			for (int k = 0; k < DIV_STEPS; k++) dv_v[k+1] <= dv_v[k];
			out_valid_q <= dv_v[DIV_STEPS];
		end
	end

	// Load the root iteration from the queue
	always_ff @(posedge clk) begin
		if (be) begin
			sq_x[0]   <= {2'b0, pop_data.dist2};
			sq_r[0]   <= '0;
			sq_idx[0] <= pop_data.idx;
			sq_w[0]   <= pop_data.w;
		end
	end

	// One bit pair of the integer square root per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] SQ_BIT = 64'd1 << (2 * (SQ_STEPS - 1 - k));
		always_ff @(posedge clk) begin
			if (be) begin
				if (sq_x[k] >= sq_r[k] + SQ_BIT) begin
					sq_x[k+1] <= sq_x[k] - (sq_r[k] + SQ_BIT);
					sq_r[k+1] <= (sq_r[k] >> 1) + SQ_BIT;
				end else begin
					sq_x[k+1] <= sq_x[k];
					sq_r[k+1] <= sq_r[k] >> 1;
				end
				sq_idx[k+1] <= sq_idx[k];
				sq_w[k+1]   <= sq_w[k];
			end
		end
	end

	// Scale the vector magnitudes by the radius
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wmag_c[i] = sq_w[SQ_STEPS][i][CRD_W-1] ? LEN_W'(-$signed(sq_w[SQ_STEPS][i]))
				: sq_w[SQ_STEPS][i][LEN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			mul_idx_s1  <= sq_idx[SQ_STEPS];
			mul_w_s1    <= sq_w[SQ_STEPS];
			mul_dist_s1 <= sq_r[SQ_STEPS][LEN_W-1:0];
			for (int i = 0; i < 3; i++) mul_n_s1[i] <= radius * wmag_c[i];
		end
	end

	// Load the division with the rounding half of the divisor
	always_ff @(posedge clk) begin
		if (be) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= 64'(mul_n_s1[i]) + 64'(mul_dist_s1 >> 1);
				dv_quo[0][i] <= '0;
			end
			dv_dist[0] <= mul_dist_s1;
			dv_idx[0]  <= mul_idx_s1;
			dv_w[0]    <= mul_w_s1;
		end
	end

	// One quotient bit per stage, three lanes
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int SH = DIV_STEPS - 1 - k;
		logic [63:0] dsh;
		assign dsh = 64'(dv_dist[k]) << SH;
		always_ff @(posedge clk) begin
			if (be) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_rem[k][i] >= dsh) begin
						dv_rem[k+1][i] <= dv_rem[k][i] - dsh;
						dv_quo[k+1][i] <= dv_quo[k][i] | (LEN_W'(1) << SH);
					end else begin
						dv_rem[k+1][i] <= dv_rem[k][i];
						dv_quo[k+1][i] <= dv_quo[k][i];
					end
				end
				dv_dist[k+1] <= dv_dist[k];
				dv_idx[k+1]  <= dv_idx[k];
				dv_w[k+1]    <= dv_w[k];
			end
		end
	end

	// Step back to the surface and saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_dist[DIV_STEPS] == '0) begin
				p_c[i] = '0;
			end else if (dv_w[DIV_STEPS][i][CRD_W-1]) begin
				p_c[i] = $signed({dv_w[DIV_STEPS][i][CRD_W-1], dv_w[DIV_STEPS][i]})
					+ $signed({2'b0, dv_quo[DIV_STEPS][i]});
			end else begin
				p_c[i] = $signed({dv_w[DIV_STEPS][i][CRD_W-1], dv_w[DIV_STEPS][i]})
					- $signed({2'b0, dv_quo[DIV_STEPS][i]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			out_idx_q <= dv_idx[DIV_STEPS];
			for (int i = 0; i < 3; i++) begin
				if (p_c[i][32] != p_c[i][31]) begin
					out_pen_q[i] <= p_c[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end else begin
					out_pen_q[i] <= p_c[i][CRD_W-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/point_capsule_collision_test_unit.sv
// Top level of the point-to-capsule collision test.
// A result passes 8 front stages (the first loaded at the accepting edge), a queue write and 66
// back stages: root load, 31 root steps, multiply, divide load, 31 divide steps, output.
// Throughput: one point per cycle; the front holds only while a hit finds the queue full,
// the back holds behind a stalled result.
// Reset: clears valids and queue pointers; capsule is base 0, axis (0, 1, 0), length 1, radius 1.
`timescale 1ns / 1ps
`default_nettype none

module point_capsule_collision_test_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// point_index, point_x, point_y, point_z
	input  logic [111:0]                        s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// hit_index, pen_x, pen_y, pen_z
	output logic [111:0]                        m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pcct_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data
);
	import pcct_pkg::*;

	pcct_cfg_t cfg_q;
	pcct_entry_t push_data, pop_data;
	pcct_qstat_t qstat;
	logic push, pop;
	logic [2:0][CRD_W-1:0] in_pt;
	logic [IDX_W-1:0] out_idx;
	logic [2:0][CRD_W-1:0] out_pen;

	assign cfg_ready = 1'b1;

	// Decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base   <= '0;
			cfg_q.axis   <= {32'd0, 32'h4000_0000, 32'd0};
			cfg_q.len    <= 31'd65536;
			cfg_q.radius <= 31'd65536;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_X: cfg_q.base[0] <= cfg_data;
				REG_BASE_Y: cfg_q.base[1] <= cfg_data;
				REG_BASE_Z: cfg_q.base[2] <= cfg_data;
				REG_AXIS_X: cfg_q.axis[0] <= cfg_data;
				REG_AXIS_Y: cfg_q.axis[1] <= cfg_data;
				REG_AXIS_Z: cfg_q.axis[2] <= cfg_data;
				REG_SEG_LENGTH: cfg_q.len <= cfg_data[LEN_W-1:0];
				REG_CAP_RADIUS: cfg_q.radius <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_pt[0] = s_axis_tdata[47:16];
	assign in_pt[1] = s_axis_tdata[79:48];
	assign in_pt[2] = s_axis_tdata[111:80];

	pcct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_idx    (s_axis_tdata[15:0]),
		.in_pt     (in_pt),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	pcct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	pcct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.radius    (cfg_q.radius),
		.qstat     (qstat),
		.pop       (pop),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_idx   (out_idx),
		.out_pen   (out_pen)
	);

	assign m_axis_tdata = {out_pen[2], out_pen[1], out_pen[0], out_idx};

endmodule

`default_nettype wire

>>> rtl/core/pcct_checker.sv
// Port-level assertions for the collision test top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module pcct_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [111:0]                    m_axis_tdata,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Input backpressure only follows an output stall
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output stall");

	// No result right out of reset
	a_rst_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result present after reset");

	// Configuration never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind point_capsule_collision_test_unit pcct_checker u_pcct_checker (.*);

`default_nettype wire
